// File: design/pbr_pkg.sv
package pbr_pkg;

    localparam int NUM_BUFFERS_DEF  = 4;
    localparam int BUFFER_BYTES_DEF = 256;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

endpackage

// File: design/packet_buffer_ring_flow_control.sv
// Channel  Dir  Ports                      Contents
// s_       in   s_tvalid/s_tready/s_tdata  packet_byte; s_tuser = mode; s_tlast = packet_end
// m_       out  m_tvalid/m_tready/m_tdata  read_byte, read_valid, buffer_done, flow_enable,
//                                          ring_full, byte_dropped
//
// For each item, the accept cycle (S_IDLE) issues the byte store and length
// reads at the tail; then S_EXEC uses the registered read data, updates the
// pointers, writes the memories and loads the result register.
// The block takes one item at a time; a stalled result holds S_EXEC.
// Reset (aresetn low, synchronous) clears the pointers and sets flow on; the
// memories are not cleared.
module packet_buffer_ring_flow_control
    import pbr_pkg::*;
#(
    parameter int NUM_BUFFERS  = NUM_BUFFERS_DEF,
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] packet_byte
    input  logic [1:0]  s_tuser,   // [1:0] mode
    input  logic        s_tlast,   // packet_end

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [7:0] read_byte, [8] read_valid, [9] buffer_done,
                                   // [10] flow_enable, [11] ring_full, [12] byte_dropped
);

    localparam int HW  = $clog2(NUM_BUFFERS);
    localparam int WCW = $clog2(BUFFER_BYTES + 1);
    localparam int RPW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
    localparam int SD  = NUM_BUFFERS * BUFFER_BYTES;
    localparam int AW  = (SD > 1) ? $clog2(SD) : 1;

    logic [7:0]     store_mem [SD];
    logic [WCW-1:0] len_mem   [NUM_BUFFERS];

    state_t         state_reg, state_next;
    logic [HW-1:0]  head_reg, head_next;
    logic [HW-1:0]  tail_reg, tail_next;
    logic           full_reg, full_next;
    logic [RPW-1:0] rp_reg, rp_next;
    logic [WCW-1:0] wc_reg, wc_next;
    logic           disc_reg, disc_next;
    logic           flow_reg, flow_next;

    mode_t          mode_reg;
    logic [7:0]     byte_reg;
    logic           end_reg;

    logic [7:0]     store_rdata;
    logic [WCW-1:0] len_rdata;

    logic           out_valid_reg;
    logic [15:0]    out_data_reg;

    logic           accept;
    logic           exec_go;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  wr_addr;
    logic           store_we;
    logic           len_we;
    logic [WCW-1:0] wc_inc;
    logic [WCW-1:0] rp_inc;
    logic [HW-1:0]  head_adv;
    logic [HW-1:0]  tail_adv;
    logic [7:0]     rd_byte;
    logic           rd_valid;
    logic           done;
    logic           dropped;
    logic           disc_now;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign exec_go  = (state_reg == S_EXEC) && (!out_valid_reg || m_tready);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign rd_addr  = AW'(tail_reg) * AW'(BUFFER_BYTES) + AW'(rp_reg);
    assign wr_addr  = AW'(head_reg) * AW'(BUFFER_BYTES) + AW'(wc_reg);
    assign wc_inc   = wc_reg + WCW'(1);
    assign rp_inc   = WCW'(rp_reg) + WCW'(1);
    assign head_adv = (head_reg == HW'(NUM_BUFFERS - 1)) ? '0 : head_reg + HW'(1);
    assign tail_adv = (tail_reg == HW'(NUM_BUFFERS - 1)) ? '0 : tail_reg + HW'(1);

    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_mem[wr_addr] <= byte_reg;
        end
        if (accept) begin
            store_rdata <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (len_we) begin
            len_mem[head_reg] <= wc_next;
        end
        if (accept) begin
            len_rdata <= len_mem[tail_reg];
        end
    end

    always_comb begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        full_next  = full_reg;
        rp_next    = rp_reg;
        wc_next    = wc_reg;
        disc_next  = disc_reg;
        flow_next  = flow_reg;
        store_we   = 1'b0;
        len_we     = 1'b0;
        rd_byte    = 8'd0;
        rd_valid   = 1'b0;
        done       = 1'b0;
        dropped    = 1'b0;
        disc_now   = disc_reg || (wc_reg == '0 && full_reg);

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_go) begin
                    state_next = S_IDLE;
                    unique case (mode_reg)
                        MODE_WRITE: begin
                            if (disc_now) begin
                                // whole packet dropped while ring was full at its start
                                dropped   = 1'b1;
                                disc_next = !end_reg;
                                if (end_reg) begin
                                    wc_next = '0;
                                end
                            end else begin
                                if (wc_reg < WCW'(BUFFER_BYTES)) begin
                                    store_we = 1'b1;
                                    wc_next  = wc_inc;
                                end else begin
                                    dropped = 1'b1;
                                end
                                if (end_reg) begin
                                    len_we    = 1'b1;  // writes wc_next before it is zeroed below
                                    head_next = head_adv;
                                    if (head_adv == tail_reg) begin
                                        full_next = 1'b1;
                                        flow_next = 1'b0;
                                    end
                                end
                            end
                        end
                        MODE_READ: begin
                            if (full_reg || tail_reg != head_reg) begin
                                rd_valid = 1'b1;
                                rd_byte  = store_rdata;
                                if (rp_inc >= len_rdata) begin
                                    rp_next   = '0;
                                    tail_next = tail_adv;
                                    done      = 1'b1;
                                    full_next = 1'b0;
                                    flow_next = 1'b1;
                                end else begin
                                    rp_next = rp_inc[RPW-1:0];
                                end
                            end
                        end
                        MODE_CLEAR: begin
                            head_next = '0;
                            tail_next = '0;
                            full_next = 1'b0;
                            rp_next   = '0;
                            wc_next   = '0;
                            disc_next = 1'b0;
                            flow_next = 1'b1;
                        end
                        MODE_NOP: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // length commit uses the incremented count; zero the count after a commit
    logic [WCW-1:0] wc_final;
    assign wc_final = (mode_reg == MODE_WRITE && !disc_now && end_reg) ? '0 : wc_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            full_reg      <= 1'b0;
            rp_reg        <= '0;
            wc_reg        <= '0;
            disc_reg      <= 1'b0;
            flow_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (exec_go) begin
                head_reg      <= head_next;
                tail_reg      <= tail_next;
                full_reg      <= full_next;
                rp_reg        <= rp_next;
                wc_reg        <= wc_final;
                disc_reg      <= disc_next;
                flow_reg      <= flow_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg <= mode_t'(s_tuser);
            byte_reg <= s_tdata;
            end_reg  <= s_tlast;
        end
        if (exec_go) begin
            out_data_reg <= {3'b000, dropped, full_next, flow_next, done, rd_valid, rd_byte};
        end
    end

endmodule

// File: verif/pbr_ring_checker.sv
module pbr_ring_checker
    import pbr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    output int          fail_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NB = NUM_BUFFERS_DEF;
    localparam int BB = BUFFER_BYTES_DEF;
    localparam int IW = $clog2(NB);
    localparam int PW = $clog2(BB);
    localparam int CW = $clog2(BB + 1);

    typedef struct packed {
        logic [7:0] read_byte;
        logic       read_valid;
        logic       buffer_done;
        logic       flow_enable;
        logic       ring_full;
        logic       byte_dropped;
    } ring_status_t;

    // shadow copy of the ring
    logic [7:0]    ring_bytes [NB*BB];
    logic [CW-1:0] pkt_len [NB];
    logic [IW-1:0] head_slot, tail_slot;
    logic [PW-1:0] rd_pos;
    logic [CW-1:0] wr_count;
    logic          is_full, flow_on, discarding;

    ring_status_t status_q [$];
    int errs;

    assign fail_count = errs;

    function automatic logic [IW-1:0] next_slot(logic [IW-1:0] i);
        return (int'(i) == NB - 1) ? '0 : i + 1'b1;
    endfunction

    function automatic void clear_ring();
        head_slot  = '0;
        tail_slot  = '0;
        is_full    = 1'b0;
        rd_pos     = '0;
        wr_count   = '0;
        discarding = 1'b0;
        flow_on    = 1'b1;
    endfunction

    function automatic ring_status_t step_ring(mode_t md, logic [7:0] data, logic last);
        ring_status_t r;
        logic [CW:0]  rp_next;
        r = '0;
        case (md)
            MODE_WRITE: begin
                if (!discarding && wr_count == 0 && is_full)
                    discarding = 1'b1;
                if (discarding) begin
                    r.byte_dropped = 1'b1;
                    if (last) begin
                        discarding = 1'b0;
                        wr_count   = '0;
                    end
                end else begin
                    if (wr_count < BB) begin
                        ring_bytes[int'(head_slot)*BB + int'(wr_count)] = data;
                        wr_count++;
                    end else begin
                        r.byte_dropped = 1'b1;
                    end
                    if (last) begin
                        pkt_len[head_slot] = wr_count;
                        wr_count  = '0;
                        head_slot = next_slot(head_slot);
                        if (head_slot == tail_slot) begin
                            is_full = 1'b1;
                            flow_on = 1'b0;
                        end
                    end
                end
            end
            MODE_READ: begin
                if (is_full || tail_slot != head_slot) begin
                    r.read_byte  = ring_bytes[int'(tail_slot)*BB + int'(rd_pos)];
                    r.read_valid = 1'b1;
                    rp_next = (CW+1)'(rd_pos) + (CW+1)'(1);
                    if (rp_next >= pkt_len[tail_slot]) begin
                        rd_pos        = '0;
                        tail_slot     = next_slot(tail_slot);
                        r.buffer_done = 1'b1;
                        if (is_full) begin
                            is_full = 1'b0;
                            flow_on = 1'b1;
                        end
                    end else begin
                        rd_pos = rp_next[PW-1:0];
                    end
                end
            end
            MODE_CLEAR: clear_ring();
            default: ;
        endcase
        r.flow_enable = flow_on;
        r.ring_full   = is_full;
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errs++;
        end
    endfunction

    initial begin
        errs = 0;
        pending_count = 0;
        clear_ring();
    end

    always @(posedge aclk) begin
        ring_status_t want;
        if (!aresetn) begin
            clear_ring();
            status_q.delete();
        end else begin
            if (s_tvalid && s_tready)
                status_q.push_back(step_ring(mode_t'(s_tuser), s_tdata, s_tlast));
            if (m_tvalid && m_tready) begin
                if (status_q.size() == 0) begin
                    $error("result item with no expectation waiting: %0h", m_tdata);
                    errs++;
                end else begin
                    want = status_q.pop_front();
                    check_field("read_byte", want.read_byte, m_tdata[7:0]);
                    check_field("read_valid", want.read_valid, m_tdata[8]);
                    check_field("buffer_done", want.buffer_done, m_tdata[9]);
                    check_field("flow_enable", want.flow_enable, m_tdata[10]);
                    check_field("ring_full", want.ring_full, m_tdata[11]);
                    check_field("byte_dropped", want.byte_dropped, m_tdata[12]);
                end
            end
        end
        pending_count <= status_q.size();
    end

endmodule

// File: verif/tb_packet_buffer_ring_flow_control.sv
module tb_packet_buffer_ring_flow_control;
    timeunit 1ns;
    timeprecision 1ps;

    import pbr_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [1:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    int mismatches;
    int pending;
    int sent_count;
    int results_seen;
    int src_idle_odds;
    bit quiet;

    packet_buffer_ring_flow_control dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    pbr_ring_checker ring_chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (mismatches),
        .pending_count (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // result side: short random stalls, one long hold-off to back the ring up
    initial begin
        int stall_left;
        bit held_long;
        stall_left   = 0;
        held_long    = 1'b0;
        results_seen = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready)
                results_seen++;
            if (!held_long && results_seen >= 300) begin
                held_long = 1'b1;
                m_tready <= 1'b0;
                repeat (120) @(posedge aclk);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!quiet && (results_seen / 64) % 3 != 0
                         && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 7) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= aresetn;
            end
        end
    end

    task automatic push_item(mode_t md, logic [7:0] data, logic last);
        if (!quiet && src_idle_odds > 0 && $urandom_range(1, src_idle_odds) == 1) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= md;
        s_tdata  <= data;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_count++;
    endtask

    task automatic send_packet(int len, bit with_end);
        for (int i = 0; i < len; i++)
            push_item(MODE_WRITE, 8'($urandom), with_end && (i == len - 1));
    endtask

    task automatic read_bytes(int n);
        for (int i = 0; i < n; i++)
            push_item(MODE_READ, 8'($urandom), 1'($urandom));
    endtask

    // stop offering and wait until every expected result has arrived
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    initial begin
        int pick;
        bit mid_drain_done;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= MODE_NOP;
        s_tlast  <= 1'b0;
        quiet          = 1'b0;
        sent_count     = 0;
        src_idle_odds  = 4;
        mid_drain_done = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty read, no-op, fill all four buffers, packet while full,
        // drain, partial packet thrown away by a clear
        push_item(MODE_READ, 8'h00, 1'b0);
        push_item(MODE_NOP, 8'hFF, 1'b1);
        push_item(MODE_WRITE, 8'h00, 1'b1);
        push_item(MODE_WRITE, 8'hFF, 1'b0);
        push_item(MODE_WRITE, 8'hA5, 1'b1);
        push_item(MODE_WRITE, 8'h5A, 1'b1);
        push_item(MODE_WRITE, 8'hC3, 1'b1);
        push_item(MODE_WRITE, 8'h11, 1'b0);
        push_item(MODE_WRITE, 8'h22, 1'b1);
        read_bytes(6);
        push_item(MODE_WRITE, 8'h3C, 1'b0);
        push_item(MODE_WRITE, 8'h96, 1'b0);
        push_item(MODE_CLEAR, 8'hFF, 1'b1);
        push_item(MODE_READ, 8'hFF, 1'b1);
        push_item(MODE_CLEAR, 8'h00, 1'b0);
        wait_drained();

        // oversized packet: length saturates at the buffer size
        send_packet($urandom_range(256, 259), 1'b1);

        while (sent_count < 800) begin
            quiet = (sent_count >= 700);
            if (!mid_drain_done && sent_count >= 500) begin
                mid_drain_done = 1'b1;
                wait_drained();
            end
            if ($urandom_range(0, 9) == 0)
                src_idle_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
            pick = $urandom_range(0, 99);
            if (pick < 48)
                send_packet($urandom_range(1, 8), 1'b1);
            else if (pick < 86)
                read_bytes($urandom_range(1, 12));
            else if (pick < 89)
                push_item(MODE_CLEAR, 8'($urandom), 1'($urandom));
            else if (pick < 92) begin
                send_packet($urandom_range(1, 5), 1'b0);
                push_item(MODE_CLEAR, 8'($urandom), 1'($urandom));
            end else
                push_item(mode_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
